// ===== hdl/owtr_pkg.sv =====
// Package with the shared types, codes and helper functions of the one-wire temperature reader.
package owtr_pkg;

    localparam logic [2:0] STEP_READ_HIGH = 3'd5;
    localparam logic [2:0] STEP_READ_LOW  = 3'd4;
    localparam logic [2:0] STEP_READ_CMD  = 3'd3;
    localparam logic [2:0] STEP_CONVERT   = 3'd1;

    localparam logic [2:0] CFG_RESET_LOW_TIME   = 3'd0;
    localparam logic [2:0] CFG_PRESENCE_DELAY   = 3'd1;
    localparam logic [2:0] CFG_RESET_RECOVERY   = 3'd2;
    localparam logic [2:0] CFG_SLOT_LENGTH      = 3'd3;
    localparam logic [2:0] CFG_START_LOW_TIME   = 3'd4;
    localparam logic [2:0] CFG_READ_SAMPLE_TIME = 3'd5;
    localparam logic [2:0] CFG_CONVERSION_WAIT  = 3'd6;

    localparam logic [7:0] CMD_SKIP_ROM   = 8'hCC;
    localparam logic [7:0] CMD_CONVERT    = 8'h44;
    localparam logic [7:0] CMD_READ_SCRATCH = 8'hBE;

    typedef enum logic [2:0] {
        PH_RST_LOW   = 3'd0,
        PH_RST_WAIT  = 3'd1,
        PH_RST_RECOV = 3'd2,
        PH_SLOT      = 3'd3,
        PH_CONV      = 3'd4
    } phase_t;

    typedef struct packed {
        logic [9:0]  reset_low_time;
        logic [7:0]  presence_delay;
        logic [9:0]  reset_recovery;
        logic [7:0]  slot_length;
        logic [3:0]  start_low_time;
        logic [3:0]  read_sample_time;
        logic [19:0] conversion_wait;
    } cfg_t;

    typedef struct packed {
        logic        drive_low;
        logic        presence_seen;
        logic        temperature_valid;
        logic [15:0] temperature_tenths;
    } result_t;

    typedef struct packed {
        phase_t      phase;
        logic [2:0]  byte_step;
    } status_t;

    // Byte sent during each write step of the transaction.
    function automatic logic [7:0] step_byte(input logic [2:0] step);
        logic [7:0] b;
        case (step)
            3'd0:    b = CMD_SKIP_ROM;
            3'd1:    b = CMD_CONVERT;
            3'd2:    b = CMD_SKIP_ROM;
            3'd3:    b = CMD_READ_SCRATCH;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Signed sixteenths of a degree to tenths, rounded as floor((raw*10+8)/16).
    function automatic logic [15:0] to_tenths(input logic [7:0] hi, input logic [7:0] lo);
        logic signed [20:0] ext;
        logic signed [20:0] v;
        ext = {{5{hi[7]}}, hi, lo};
        v = (ext <<< 3) + (ext <<< 1) + 21'sd8;
        return v[19:4];
    endfunction

endpackage

// ===== hdl/onewire_temperature_reader.sv =====
// Top level of the one-wire temperature reader: configuration, tick stream and result register.
//
//  Channel   Direction  Transfer when           Payload
//  s_*       in         s_tvalid && s_tready    one microsecond tick with the sampled bus level
//  m_*       out        m_tvalid && m_tready    bus drive, presence, new-reading flag, temperature
//  cfg_*     in         cfg_we                  register write, no wait, no read-back
//
// The sequencer state and the result are computed by short logic between the state registers
// and the output register, so ticks can be taken back to back while m_* does not stall.
// s_tready is high whenever the output register is empty or is being drained in the same
// cycle, so a waiting result does not stop the next tick.
// rst_n is asynchronous and active low; it puts the sequencer at the start of a reset
// pulse and loads the register defaults. A stall on m_* holds the result and the state.
module onewire_temperature_reader
    import owtr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Tick input. s_tdata fields from bit 0: bus_level (1), zero fill (7).
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    // Result output. m_tdata fields from bit 0: drive_low (1), presence_seen (1),
    // temperature_valid (1), temperature_tenths (16, signed), zero fill (5).
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [19:0] cfg_data
);

    cfg_t    cfg_reg;
    result_t res;
    status_t status;
    result_t out_reg;
    logic    out_valid_reg;
    logic    accept;

    // Configuration registers take writes at any time; unknown indices are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_time   <= 10'd500;
            cfg_reg.presence_delay   <= 8'd38;
            cfg_reg.reset_recovery   <= 10'd142;
            cfg_reg.slot_length      <= 8'd77;
            cfg_reg.start_low_time   <= 4'd1;
            cfg_reg.read_sample_time <= 4'd2;
            cfg_reg.conversion_wait  <= 20'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RESET_LOW_TIME:   cfg_reg.reset_low_time   <= cfg_data[9:0];
                CFG_PRESENCE_DELAY:   cfg_reg.presence_delay   <= cfg_data[7:0];
                CFG_RESET_RECOVERY:   cfg_reg.reset_recovery   <= cfg_data[9:0];
                CFG_SLOT_LENGTH:      cfg_reg.slot_length      <= cfg_data[7:0];
                CFG_START_LOW_TIME:   cfg_reg.start_low_time   <= cfg_data[3:0];
                CFG_READ_SAMPLE_TIME: cfg_reg.read_sample_time <= cfg_data[3:0];
                CFG_CONVERSION_WAIT:  cfg_reg.conversion_wait  <= cfg_data;
                default:              ;
            endcase
        end
    end

    // A tick is taken whenever the output register is free or frees up this cycle.
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    owtr_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (accept),
        .bus_level (s_tdata[0]),
        .cfg       (cfg_reg),
        .res       (res),
        .status    (status)
    );

    // Output register: the result of each accepted tick waits here for its transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg.temperature_tenths, out_reg.temperature_valid,
                       out_reg.presence_seen, out_reg.drive_low};

    // A completed reading always closes the loop and restarts at a reset pulse.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && res.temperature_valid |=>
            status.phase == PH_RST_LOW && status.byte_step == 3'd0)
        else $error("sequencer did not restart after a reading");

    // The transaction never goes past the high data byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        status.byte_step <= STEP_READ_HIGH)
        else $error("byte step out of range");

    // Sequencer state moves only on a tick transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(status))
        else $error("sequencer state changed without a tick");

    // Every accepted tick leaves a result waiting in the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_tvalid)
        else $error("result of an accepted tick was lost");

endmodule

// ===== hdl/owtr_seq.sv =====
// Bus sequencer of the one-wire temperature reader: phases, slot timing and byte assembly.
module owtr_seq
    import owtr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  logic    bus_level,
    input  cfg_t    cfg,
    output result_t res,
    output status_t status
);

    phase_t      phase_reg, phase_next;
    logic [19:0] tick_reg, tick_next;
    logic [2:0]  bit_reg, bit_next;
    logic [2:0]  step_reg, step_next;
    logic [7:0]  shift_reg, shift_next;
    logic [7:0]  low_reg, low_next;
    logic        presence_reg, presence_next;
    logic [15:0] temp_reg, temp_next;

    logic [19:0] dur;
    logic [19:0] dur_min;
    logic [20:0] tick_inc;
    logic        timed_hit;
    logic [3:0]  slot_s;
    logic [3:0]  smp;
    logic [8:0]  last_w;
    logic [8:0]  smp_p1;
    logic [8:0]  last;
    logic        reading;
    logic        slot_end;
    logic        byte_done;
    logic        sample_now;
    logic [7:0]  sampled;

    always_comb
    begin
        case (phase_reg)
            PH_RST_WAIT:  dur = {12'd0, cfg.presence_delay};
            PH_RST_RECOV: dur = {10'd0, cfg.reset_recovery};
            PH_CONV:      dur = cfg.conversion_wait;
            default:      dur = {10'd0, cfg.reset_low_time};
        endcase
    end

    assign dur_min   = (dur == 20'd0) ? 20'd1 : dur;
    assign tick_inc  = {1'b0, tick_reg} + 21'd1;
    assign timed_hit = tick_inc >= {1'b0, dur_min};

    assign slot_s     = (cfg.start_low_time == 4'd0) ? 4'd1 : cfg.start_low_time;
    assign smp        = (cfg.read_sample_time > slot_s) ? cfg.read_sample_time : slot_s;
    assign reading    = step_reg[2];
    assign last_w     = {5'd0, slot_s} + {1'b0, cfg.slot_length};
    assign smp_p1     = {5'd0, smp} + 9'd1;
    assign last       = (reading && (last_w < smp_p1)) ? smp_p1 : last_w;
    assign slot_end   = tick_reg >= {11'd0, last};
    assign byte_done  = slot_end && (bit_reg == 3'd7);
    assign sample_now = reading && (tick_reg == {16'd0, smp});
    assign sampled    = sample_now ? {bus_level, shift_reg[7:1]} : shift_reg;

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_RST_LOW:   if (timed_hit) phase_next = PH_RST_WAIT;
            PH_RST_WAIT:  if (timed_hit) phase_next = PH_RST_RECOV;
            PH_RST_RECOV: if (timed_hit) phase_next = PH_SLOT;
            PH_SLOT:
            begin
                if (byte_done && step_reg == STEP_CONVERT)
                    phase_next = (cfg.conversion_wait != 20'd0) ? PH_CONV : PH_RST_LOW;
                else if (byte_done && step_reg == STEP_READ_HIGH)
                    phase_next = PH_RST_LOW;
            end
            PH_CONV:      if (timed_hit) phase_next = PH_RST_LOW;
            default:      phase_next = PH_RST_LOW;
        endcase
    end

    // Counters and data path.
    always_comb
    begin
        tick_next     = tick_reg;
        bit_next      = bit_reg;
        step_next     = step_reg;
        shift_next    = shift_reg;
        low_next      = low_reg;
        presence_next = presence_reg;
        temp_next     = temp_reg;
        case (phase_reg)
            PH_SLOT:
            begin
                shift_next = sampled;
                if (slot_end)
                begin
                    tick_next = 20'd0;
                    if (!reading)
                        shift_next = {1'b0, shift_reg[7:1]};
                    if (bit_reg != 3'd7)
                        bit_next = bit_reg + 3'd1;
                    else
                    begin
                        bit_next = 3'd0;
                        case (step_reg)
                            STEP_CONVERT:
                                step_next = step_reg + 3'd1;
                            STEP_READ_CMD:
                            begin
                                step_next  = STEP_READ_LOW;
                                shift_next = 8'd0;
                            end
                            STEP_READ_LOW:
                            begin
                                low_next   = sampled;
                                step_next  = STEP_READ_HIGH;
                                shift_next = 8'd0;
                            end
                            STEP_READ_HIGH:
                            begin
                                temp_next = to_tenths(sampled, low_reg);
                                step_next = 3'd0;
                            end
                            default:
                            begin
                                step_next  = step_reg + 3'd1;
                                shift_next = step_byte(step_reg + 3'd1);
                            end
                        endcase
                    end
                end
                else
                    tick_next = tick_inc[19:0];
            end
            default:
            begin
                tick_next = timed_hit ? 20'd0 : tick_inc[19:0];
                if (timed_hit && phase_reg == PH_RST_WAIT)
                    presence_next = !bus_level;
                if (timed_hit && phase_reg == PH_RST_RECOV)
                begin
                    shift_next = step_byte(step_reg);
                    bit_next   = 3'd0;
                end
            end
        endcase
    end

    // Result of the current tick.
    always_comb
    begin
        res.drive_low          = 1'b0;
        res.temperature_valid  = 1'b0;
        res.presence_seen      = presence_next;
        res.temperature_tenths = temp_next;
        case (phase_reg)
            PH_RST_WAIT, PH_RST_RECOV, PH_CONV: res.drive_low = 1'b0;
            PH_SLOT:
            begin
                res.drive_low = (tick_reg < {16'd0, slot_s}) ||
                                (!reading && !shift_reg[0] && (tick_reg < {11'd0, last_w}));
                res.temperature_valid = byte_done && (step_reg == STEP_READ_HIGH);
            end
            default: res.drive_low = 1'b1;
        endcase
    end

    assign status.phase     = phase_reg;
    assign status.byte_step = step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_RST_LOW;
            tick_reg     <= 20'd0;
            bit_reg      <= 3'd0;
            step_reg     <= 3'd0;
            shift_reg    <= 8'd0;
            low_reg      <= 8'd0;
            presence_reg <= 1'b0;
            temp_reg     <= 16'd0;
        end
        else if (en)
        begin
            phase_reg    <= phase_next;
            tick_reg     <= tick_next;
            bit_reg      <= bit_next;
            step_reg     <= step_next;
            shift_reg    <= shift_next;
            low_reg      <= low_next;
            presence_reg <= presence_next;
            temp_reg     <= temp_next;
        end
    end

endmodule

// ===== dv/owtr_checker.sv =====
// Checker for the one-wire temperature reader: predicts every result transfer and compares it.
module owtr_checker
    import owtr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [19:0] cfg_data,
    output int          fail_count,
    output int          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam cfg_t CFG_DEFAULTS = '{
        reset_low_time:   10'd500,
        presence_delay:   8'd38,
        reset_recovery:   10'd142,
        slot_length:      8'd77,
        start_low_time:   4'd1,
        read_sample_time: 4'd2,
        conversion_wait:  20'd0
    };

    cfg_t        regs;
    phase_t      seq_phase;
    int unsigned ticks;
    logic [2:0]  bit_pos;
    logic [2:0]  step;
    logic [7:0]  shreg;
    logic [7:0]  low_rd;
    logic        present;
    logic [15:0] tenths_q;
    int          errors;
    result_t     predicted_outputs[$];

    function automatic int unsigned one_if_zero(input int unsigned v);
        return (v == 0) ? 1 : v;
    endfunction

    // Advances a timed phase; returns 1 when its last tick has just gone by.
    function automatic bit timer_expired(input int unsigned dur);
        if (ticks + 1 >= one_if_zero(dur))
        begin
            ticks = 0;
            return 1'b1;
        end
        ticks = (ticks + 1) & 32'h000F_FFFF;
        return 1'b0;
    endfunction

    function automatic logic [7:0] command_byte(input logic [2:0] st);
        if (st == STEP_CONVERT)
            return CMD_CONVERT;
        else if (st == STEP_READ_CMD)
            return CMD_READ_SCRATCH;
        else if (st < STEP_READ_LOW)
            return CMD_SKIP_ROM;
        return 8'h00;
    endfunction

    // Sixteenths of a degree (signed) to tenths, rounding half up via a floor shift.
    function automatic logic [15:0] tenths_of(input logic [7:0] hi, input logic [7:0] lo);
        logic signed [15:0] raw;
        int                 scaled;
        raw = {hi, lo};
        scaled = (int'(raw) * 10 + 8) >>> 4;
        return scaled[15:0];
    endfunction

    function automatic result_t predict_tick_output(input logic level);
        result_t     r;
        int unsigned s;
        int unsigned smp;
        int unsigned last;
        int unsigned t;
        bit          reading;
        r = '0;
        case (seq_phase)
            PH_RST_WAIT:
                if (timer_expired(regs.presence_delay))
                begin
                    present = !level;
                    seq_phase = PH_RST_RECOV;
                end
            PH_RST_RECOV:
                if (timer_expired(regs.reset_recovery))
                begin
                    shreg = command_byte(step);
                    bit_pos = '0;
                    seq_phase = PH_SLOT;
                end
            PH_SLOT:
            begin
                s = one_if_zero(regs.start_low_time);
                reading = (step >= STEP_READ_LOW);
                t = ticks;
                last = s + regs.slot_length;
                if (reading)
                begin
                    smp = (regs.read_sample_time > s) ? regs.read_sample_time : s;
                    if (last < smp + 1)
                        last = smp + 1;
                    if (t < s)
                        r.drive_low = 1'b1;
                    if (t == smp)
                        shreg = {level, shreg[7:1]};
                end
                else if (t < s || (!shreg[0] && t < s + regs.slot_length))
                    r.drive_low = 1'b1;
                if (t >= last)
                begin
                    ticks = 0;
                    if (!reading)
                        shreg = shreg >> 1;
                    if (bit_pos < 3'd7)
                        bit_pos = bit_pos + 3'd1;
                    else
                    begin
                        bit_pos = '0;
                        case (step)
                            STEP_CONVERT:
                            begin
                                step = STEP_CONVERT + 3'd1;
                                seq_phase = (regs.conversion_wait != 0) ? PH_CONV : PH_RST_LOW;
                            end
                            STEP_READ_CMD:
                            begin
                                step = STEP_READ_LOW;
                                shreg = '0;
                            end
                            STEP_READ_LOW:
                            begin
                                low_rd = shreg;
                                step = STEP_READ_HIGH;
                                shreg = '0;
                            end
                            STEP_READ_HIGH:
                            begin
                                tenths_q = tenths_of(shreg, low_rd);
                                r.temperature_valid = 1'b1;
                                step = '0;
                                seq_phase = PH_RST_LOW;
                            end
                            default:
                            begin
                                step = step + 3'd1;
                                shreg = command_byte(step);
                            end
                        endcase
                    end
                end
                else
                    ticks = t + 1;
            end
            PH_CONV:
                if (timer_expired(regs.conversion_wait))
                    seq_phase = PH_RST_LOW;
            default:
            begin
                r.drive_low = 1'b1;
                if (timer_expired(regs.reset_low_time))
                    seq_phase = PH_RST_WAIT;
            end
        endcase
        r.presence_seen = present;
        r.temperature_tenths = tenths_q;
        return r;
    endfunction

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            regs = CFG_DEFAULTS;
            seq_phase = PH_RST_LOW;
            ticks = 0;
            bit_pos = '0;
            step = '0;
            shreg = '0;
            low_rd = '0;
            present = 1'b0;
            tenths_q = '0;
            errors = 0;
            predicted_outputs.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (predicted_outputs.size() == 0)
                begin
                    $display("%0t ns: result transfer with no tick waiting, actual %h",
                             $time, m_tdata);
                    errors++;
                end
                else
                begin
                    want = predicted_outputs.pop_front();
                    // m_tdata: drive_low, presence_seen, temperature_valid, tenths.
                    compare_field("drive_low", want.drive_low, m_tdata[0]);
                    compare_field("presence_seen", want.presence_seen, m_tdata[1]);
                    compare_field("temperature_valid", want.temperature_valid, m_tdata[2]);
                    compare_field("temperature_tenths",
                                  int'($signed(want.temperature_tenths)),
                                  int'($signed(m_tdata[18:3])));
                end
            end
            if (s_tvalid && s_tready)
                predicted_outputs.push_back(predict_tick_output(s_tdata[0]));
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RESET_LOW_TIME:   regs.reset_low_time = cfg_data[9:0];
                    CFG_PRESENCE_DELAY:   regs.presence_delay = cfg_data[7:0];
                    CFG_RESET_RECOVERY:   regs.reset_recovery = cfg_data[9:0];
                    CFG_SLOT_LENGTH:      regs.slot_length = cfg_data[7:0];
                    CFG_START_LOW_TIME:   regs.start_low_time = cfg_data[3:0];
                    CFG_READ_SAMPLE_TIME: regs.read_sample_time = cfg_data[3:0];
                    CFG_CONVERSION_WAIT:  regs.conversion_wait = cfg_data;
                    default:              ;
                endcase
            end
        end
        fail_count <= errors;
        pending_count <= predicted_outputs.size();
    end

endmodule

// ===== dv/testbench.sv =====
// Top of the one-wire temperature reader testbench: clock, reset, stimulus and verdict.
module testbench;
    import owtr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Index that no register answers to; writes to it must change nothing.
    localparam logic [2:0] CFG_UNUSED = 3'd7;

    // How the sampled bus level is chosen for the ticks of a phase.
    localparam int LEVEL_RANDOM      = 0;
    localparam int LEVEL_MOSTLY_HIGH = 1;
    localparam int LEVEL_MOSTLY_LOW  = 2;
    localparam int LEVEL_ALTERNATE   = 3;

    // Phases of the random part that get special treatment.
    localparam int MAX_PHASE   = 1;
    localparam int HOLD_PHASE  = 3;
    localparam int QUIET_PHASE = 5;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [19:0] cfg_data;

    int fail_count;
    int pending_count;
    int ticks_sent;
    int hold_requests;
    int holds_served;
    int hold_left;
    int phase_no;
    bit quiet_window;

    onewire_temperature_reader u_top (.*);

    owtr_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard limit on the run. A correct run needs well under a tenth of this.
    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Receiver. It drops m_tready about 21 times in a hundred, never inside the quiet
    // window, and serves each hold-off request with a long stall of its own. During that
    // stall the output register fills and the block has to push back on its tick input.
    initial
    begin
        m_tready = 1'b0;
        hold_left = 0;
        holds_served = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && holds_served < hold_requests)
            begin
                hold_left = 300;
                holds_served++;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (quiet_window)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99) >= 21);
        end
    end

    // Offers one tick, with random idle cycles in front of it, and returns at the edge
    // where the transfer happens. s_tvalid is left high so that a following tick can
    // keep it up without a gap.
    task automatic send_tick(input logic level);
        while (!quiet_window && $urandom_range(99) < 21)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'b0, level};
        do
            @(posedge clk);
        while (!s_tready);
        ticks_sent++;
    endtask

    // Sends a run of ticks, then stops offering and waits until every predicted result
    // has been taken, so that the block is idle for the next register writes.
    task automatic run_phase(input int n_ticks, input int mode);
        logic level;
        for (int i = 0; i < n_ticks; i++)
        begin
            case (mode)
                LEVEL_RANDOM:      level = $urandom_range(1);
                LEVEL_MOSTLY_HIGH: level = ($urandom_range(9) != 0);
                LEVEL_MOSTLY_LOW:  level = ($urandom_range(9) == 0);
                default:           level = i[0];
            endcase
            send_tick(level);
        end
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_count != 0);
    endtask

    // Puts random junk above a register's width when asked, to show that it is masked.
    function automatic logic [19:0] with_stray_bits(input logic [19:0] value, input int width,
                                                    input bit garble);
        if (garble && width < 20)
            return value | (20'($urandom) << width);
        return value;
    endfunction

    // Writes one register and leaves the write enable high for a following write.
    task automatic write_reg(input logic [2:0] idx, input logic [19:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic load_registers(input cfg_t c, input bit garble);
        write_reg(CFG_RESET_LOW_TIME, with_stray_bits(20'(c.reset_low_time), 10, garble));
        write_reg(CFG_PRESENCE_DELAY, with_stray_bits(20'(c.presence_delay), 8, garble));
        write_reg(CFG_RESET_RECOVERY, with_stray_bits(20'(c.reset_recovery), 10, garble));
        write_reg(CFG_SLOT_LENGTH, with_stray_bits(20'(c.slot_length), 8, garble));
        write_reg(CFG_START_LOW_TIME, with_stray_bits(20'(c.start_low_time), 4, garble));
        write_reg(CFG_READ_SAMPLE_TIME, with_stray_bits(20'(c.read_sample_time), 4, garble));
        write_reg(CFG_CONVERSION_WAIT, c.conversion_wait);
        write_reg(CFG_UNUSED, 20'($urandom));
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        cfg_t next_cfg;
        int   n_ticks;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        quiet_window = 1'b0;
        hold_requests = 0;
        ticks_sent = 0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. A few ticks with the reset values of the registers, then every
        // register at zero: zero durations act as one tick, a zero start-low or sample
        // time acts as one, and a zero conversion wait skips the wait. The zero setting
        // runs long enough for one whole read loop. The bus level alternates so both
        // presence answers show up.
        run_phase(12, LEVEL_ALTERNATE);
        load_registers('0, 1'b0);
        run_phase(140, LEVEL_ALTERNATE);

        // Random part. Most phases use short timings so that whole read loops complete
        // and random bits land in the scratchpad bytes; one phase puts every register at
        // its largest value for a stretch of the reset pulse.
        // Every new setting arrives while the sequencer is somewhere inside a loop.
        phase_no = 0;
        while ((ticks_sent < 900 || phase_no <= QUIET_PHASE) && phase_no < 150)
        begin
            if (phase_no == MAX_PHASE)
            begin
                next_cfg = '{
                    reset_low_time:   10'h3FF,
                    presence_delay:   8'hFF,
                    reset_recovery:   10'h3FF,
                    slot_length:      8'hFF,
                    start_low_time:   4'hF,
                    read_sample_time: 4'hF,
                    conversion_wait:  20'hF_FFFF
                };
                n_ticks = 100;
            end
            else
            begin
                next_cfg.reset_low_time = 10'($urandom_range(4));
                next_cfg.presence_delay = 8'($urandom_range(4));
                next_cfg.reset_recovery = 10'($urandom_range(4));
                next_cfg.slot_length = 8'($urandom_range(4));
                next_cfg.start_low_time = 4'($urandom_range(2));
                next_cfg.read_sample_time = 4'($urandom_range(3));
                next_cfg.conversion_wait = '0;
                if ($urandom_range(3) == 0)
                begin
                    next_cfg.start_low_time = 4'($urandom_range(15));
                    next_cfg.read_sample_time = 4'($urandom_range(15));
                end
                if ($urandom_range(5) == 0)
                begin
                    next_cfg.reset_low_time = 10'($urandom_range(60));
                    next_cfg.slot_length = 8'($urandom_range(20));
                end
                if ($urandom_range(1) == 0)
                    next_cfg.conversion_wait = 20'($urandom_range(1, 8));
                n_ticks = $urandom_range(50, 150);
            end

            // One phase with a long receiver stall while ticks keep coming, and one
            // phase in which neither side ever idles.
            if (phase_no == HOLD_PHASE)
            begin
                hold_requests++;
                n_ticks = 200;
            end
            quiet_window = (phase_no == QUIET_PHASE);
            if (quiet_window)
                n_ticks = 200;

            load_registers(next_cfg, (phase_no % 3) == 0);
            run_phase(n_ticks, $urandom_range(LEVEL_MOSTLY_LOW));
            phase_no++;
        end
        quiet_window = 1'b0;

        // Everything has drained in run_phase; give the output register a few more
        // cycles to show any result that should not be there.
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
